### hdl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared opcodes, fixed field widths and the per-cell command type of the
// multiport elastic pipeline.
// ----------------------------------------------------------------------------
package mep_pkg;

    // Fixed field widths
    localparam int OP_W   = 3;
    localparam int SLOT_W = 3;
    localparam int CNT_W  = 4;

    // Saturation limit of the entry count
    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_SET     = 3'd4;

    // Command to one slot cell: rotate the ring, optionally overwrite
    typedef struct packed {
        logic shift;
        logic load;
        logic occ;
    } t_cell_cmd;

endpackage

### hdl/mep_cell.sv
// ----------------------------------------------------------------------------
// mep_cell
// One slot of the rotating slot ring: an occupied flag and a request tag.
// On a shift it takes its neighbor's contents or a loaded value.
// ----------------------------------------------------------------------------
module mep_cell
    import mep_pkg::*;
#(
    parameter int TAG_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cell_cmd           i_cmd,
    input  logic                i_nxt_occ,
    input  logic [TAG_BITS-1:0] i_nxt_tag,
    input  logic [TAG_BITS-1:0] i_ld_tag,
    output logic                o_occ,
    output logic [TAG_BITS-1:0] o_tag
);

    logic                r_occ;
    logic [TAG_BITS-1:0] r_tag;

    // Occupied flag: clear at reset, rotate or load on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_cmd.shift) begin
            r_occ <= i_cmd.load ? i_cmd.occ : i_nxt_occ;
        end
    end

    // Tag: no reset, only read while occupied
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_tag <= i_cmd.load ? i_ld_tag : i_nxt_tag;
        end
    end

    assign o_occ = r_occ;
    assign o_tag = r_tag;

endmodule

### hdl/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer of the slot ring. Walks all slots once per transaction, issues
// loads to the cells, keeps the counts and the add pointer, and holds the
// result register.
// ----------------------------------------------------------------------------
module mep_ctrl
    import mep_pkg::*;
#(
    parameter int LANES    = 2,
    parameter int STAGES   = 4,
    parameter int TAG_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [OP_W-1:0]                   i_opcode,
    input  logic [SLOT_W-1:0]                 i_slot_position,
    input  logic [TAG_BITS-1:0]               i_entry_tag,
    input  logic                              i_entry_present,
    // ring side
    input  logic                              i_head_occ,
    input  logic [TAG_BITS-1:0]               i_head_tag,
    output t_cell_cmd [LANES*STAGES-1:0]      o_cmd,
    output logic [TAG_BITS-1:0]               o_ld_tag,
    // output channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_status,
    output logic                              o_read_valid,
    output logic [TAG_BITS-1:0]               o_read_tag,
    output logic [$clog2(LANES+1)-1:0]        o_input_stage_count,
    output logic                              o_input_stage_full,
    output logic [CNT_W-1:0]                  o_entries_held
);

    localparam int N          = LANES * STAGES;
    localparam int PW         = $clog2(N + 1);
    localparam int IW         = $clog2(N);
    localparam int LW         = $clog2(LANES + 1);
    localparam int INPUT_BASE = (STAGES - 1) * LANES;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [SLOT_W-1:0]   r_pos, n_pos;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                r_present, n_present;
    logic [PW-1:0]       r_step, n_step;
    logic [LW-1:0]       r_lane, n_lane;
    logic [PW-1:0]       r_base, n_base;
    logic [PW-1:0]       r_lo, n_lo;
    logic [PW-1:0]       r_fs, n_fs;
    logic [LW-1:0]       r_ic, n_ic;
    logic [LW-1:0]       r_input_cnt, n_input_cnt;
    logic [PW-1:0]       r_add_ptr, n_add_ptr;
    logic [CNT_W-1:0]    r_entry_cnt, n_entry_cnt;
    logic                r_refuse, n_refuse;
    logic                r_found, n_found;
    logic                r_status, n_status;
    logic                r_rvalid, n_rvalid;
    logic [TAG_BITS-1:0] r_rtag, n_rtag;
    logic                r_out_valid, n_out_valid;
    logic                r_o_status, n_o_status;
    logic                r_o_rvalid, n_o_rvalid;
    logic [TAG_BITS-1:0] r_o_rtag, n_o_rtag;
    logic [LW-1:0]       r_o_ic, n_o_ic;
    logic                r_o_full, n_o_full;
    logic [CNT_W-1:0]    r_o_cnt, n_o_cnt;

    logic                accept;
    logic                last_step;
    logic                pos_hit;
    logic                add_hit;
    logic [PW-1:0]       floor_fs;
    logic [PW:0]         dest_w;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign last_step  = (r_step == PW'(N - 1));
    assign pos_hit    = (int'(r_pos) == int'(r_step));
    assign floor_fs   = (r_fs < r_lo) ? r_lo : r_fs;
    // ring cell that holds slot floor_fs once this step's rotation is done
    assign dest_w     = {1'b0, floor_fs} + (PW + 1)'(N - 1) - {1'b0, r_step};
    assign add_hit    = !r_refuse && !r_found && (r_step >= r_add_ptr) && !i_head_occ;
    assign o_ld_tag   = (r_op == OP_ADVANCE) ? i_head_tag : r_tag;

    // Sequence the walk and compute the next state
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_pos       = r_pos;
        n_tag       = r_tag;
        n_present   = r_present;
        n_step      = r_step;
        n_lane      = r_lane;
        n_base      = r_base;
        n_lo        = r_lo;
        n_fs        = r_fs;
        n_ic        = r_ic;
        n_input_cnt = r_input_cnt;
        n_add_ptr   = r_add_ptr;
        n_entry_cnt = r_entry_cnt;
        n_refuse    = r_refuse;
        n_found     = r_found;
        n_status    = r_status;
        n_rvalid    = r_rvalid;
        n_rtag      = r_rtag;
        n_out_valid = r_out_valid;
        n_o_status  = r_o_status;
        n_o_rvalid  = r_o_rvalid;
        n_o_rtag    = r_o_rtag;
        n_o_ic      = r_o_ic;
        n_o_full    = r_o_full;
        n_o_cnt     = r_o_cnt;
        for (int k = 0; k < N; k++) begin
            o_cmd[k].shift = (r_state == S_WALK);
            o_cmd[k].load  = 1'b0;
            o_cmd[k].occ   = 1'b0;
        end

        // drop the result once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_WALK;
                    n_op      = i_opcode;
                    n_pos     = i_slot_position;
                    n_tag     = i_entry_tag;
                    n_present = i_entry_present;
                    n_step    = '0;
                    n_lane    = '0;
                    n_base    = '0;
                    n_lo      = '0;
                    n_fs      = '0;
                    n_ic      = '0;
                    n_found   = 1'b0;
                    n_status  = 1'b0;
                    n_rvalid  = 1'b0;
                    n_rtag    = '0;
                    n_refuse  = (int'(r_input_cnt) == LANES);
                end
            end

            S_WALK: begin
                // track stage boundaries of the slot under the head
                if (r_lane == LW'(LANES - 1)) begin
                    n_lane = '0;
                    n_lo   = r_base;
                    n_base = r_base + PW'(LANES);
                end else begin
                    n_lane = r_lane + LW'(1);
                end
                n_step = r_step + PW'(1);

                case (r_op)
                    OP_ADD: begin
                        if (add_hit) begin
                            o_cmd[N-1].load = 1'b1;
                            o_cmd[N-1].occ  = 1'b1;
                            n_found         = 1'b1;
                            n_add_ptr       = r_step + PW'(1);
                            n_input_cnt     = r_input_cnt + LW'(1);
                            if (r_entry_cnt != CNT_MAX) begin
                                n_entry_cnt = r_entry_cnt + CNT_W'(1);
                            end
                        end
                        if (last_step) begin
                            n_status = r_refuse || !(r_found || add_hit);
                            if (!r_refuse && !(r_found || add_hit)) begin
                                n_add_ptr = PW'(N);
                            end
                        end
                    end
                    OP_ADVANCE: begin
                        n_ic = r_ic;
                        n_fs = r_fs;
                        if (i_head_occ) begin
                            n_fs = floor_fs + PW'(1);
                            if (floor_fs < r_step) begin
                                // move one stage toward the head into the free slot
                                for (int k = 0; k < N; k++) begin
                                    if (dest_w[IW-1:0] == IW'(k)) begin
                                        o_cmd[k].load = 1'b1;
                                        o_cmd[k].occ  = 1'b1;
                                    end
                                end
                                o_cmd[N-1].load = 1'b1;
                                o_cmd[N-1].occ  = 1'b0;
                                if (floor_fs >= PW'(INPUT_BASE)) begin
                                    n_ic = r_ic + LW'(1);
                                end
                            end else if (r_step >= PW'(INPUT_BASE)) begin
                                n_ic = r_ic + LW'(1);
                            end
                        end
                        if (last_step) begin
                            n_input_cnt = n_ic;
                            n_add_ptr   = (n_ic == '0) ? PW'(INPUT_BASE) : n_fs;
                        end
                    end
                    OP_PEEK: begin
                        if (pos_hit && (int'(r_pos) < LANES) && i_head_occ) begin
                            n_rvalid = 1'b1;
                            n_rtag   = i_head_tag;
                        end
                    end
                    OP_CLEAR: begin
                        if (pos_hit) begin
                            o_cmd[N-1].load = 1'b1;
                            o_cmd[N-1].occ  = 1'b0;
                            if (r_entry_cnt != '0) begin
                                n_entry_cnt = r_entry_cnt - CNT_W'(1);
                            end
                        end
                    end
                    OP_SET: begin
                        if (pos_hit) begin
                            o_cmd[N-1].load = 1'b1;
                            o_cmd[N-1].occ  = r_present;
                        end
                    end
                    default: begin
                    end
                endcase

                if (last_step) begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                // hand the result over once the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_status;
                    n_o_rvalid  = r_rvalid;
                    n_o_rtag    = r_rtag;
                    n_o_ic      = r_input_cnt;
                    n_o_full    = (int'(r_input_cnt) == LANES);
                    n_o_cnt     = r_entry_cnt;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_input_cnt <= '0;
            r_add_ptr   <= PW'(INPUT_BASE);
            r_entry_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_input_cnt <= n_input_cnt;
            r_add_ptr   <= n_add_ptr;
            r_entry_cnt <= n_entry_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // Transaction payload and walk registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pos      <= n_pos;
        r_tag      <= n_tag;
        r_present  <= n_present;
        r_step     <= n_step;
        r_lane     <= n_lane;
        r_base     <= n_base;
        r_lo       <= n_lo;
        r_fs       <= n_fs;
        r_ic       <= n_ic;
        r_refuse   <= n_refuse;
        r_found    <= n_found;
        r_status   <= n_status;
        r_rvalid   <= n_rvalid;
        r_rtag     <= n_rtag;
        r_o_status <= n_o_status;
        r_o_rvalid <= n_o_rvalid;
        r_o_rtag   <= n_o_rtag;
        r_o_ic     <= n_o_ic;
        r_o_full   <= n_o_full;
        r_o_cnt    <= n_o_cnt;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_o_status;
    assign o_read_valid        = r_o_rvalid;
    assign o_read_tag          = r_o_rtag;
    assign o_input_stage_count = r_o_ic;
    assign o_input_stage_full  = r_o_full;
    assign o_entries_held      = r_o_cnt;

endmodule

### hdl/multiport_elastic_pipeline.sv
// ----------------------------------------------------------------------------
// multiport_elastic_pipeline
// Pipe of request tags in STAGES stages of LANES slots, built as a rotating
// ring of slot cells under a walking sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall carries one operation per
//   transaction: add, advance, peek, clear or set, with slot, tag and
//   present flag. Output channel o_out_valid / i_out_stall returns exactly
//   one result per operation: status, peek data, input stage count and full
//   flag, and the entry count.
//   Every operation rotates the slot ring once, one slot per cycle, so the
//   ring of LANES*STAGES cells sets the timing of each transaction.
//   One transaction is in flight at a time; o_in_stall stays high from
//   acceptance until its result has entered the output register.
//   If the receiver stalls, the result is held in the output register and
//   a finished following result waits in the sequencer until it is free.
//   Synchronous reset empties every slot, zeroes the counts, points the
//   add pointer at the first input stage slot and drops o_out_valid.
// ----------------------------------------------------------------------------
module multiport_elastic_pipeline
    import mep_pkg::*;
#(
    parameter int LANES    = 2,
    parameter int STAGES   = 4,
    parameter int TAG_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [OP_W-1:0]            i_opcode,
    input  logic [SLOT_W-1:0]          i_slot_position,
    input  logic [TAG_BITS-1:0]        i_entry_tag,
    input  logic                       i_entry_present,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_status,
    output logic                       o_read_valid,
    output logic [TAG_BITS-1:0]        o_read_tag,
    output logic [$clog2(LANES+1)-1:0] o_input_stage_count,
    output logic                       o_input_stage_full,
    output logic [CNT_W-1:0]           o_entries_held
);

    localparam int N = LANES * STAGES;

    t_cell_cmd [N-1:0]   w_cmd;
    logic [TAG_BITS-1:0] w_ld_tag;
    logic                w_occ [N];
    logic [TAG_BITS-1:0] w_tag [N];

    // Sequencer and result register
    mep_ctrl #(
        .LANES    (LANES),
        .STAGES   (STAGES),
        .TAG_BITS (TAG_BITS)
    ) u_ctrl (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_opcode            (i_opcode),
        .i_slot_position     (i_slot_position),
        .i_entry_tag         (i_entry_tag),
        .i_entry_present     (i_entry_present),
        .i_head_occ          (w_occ[0]),
        .i_head_tag          (w_tag[0]),
        .o_cmd               (w_cmd),
        .o_ld_tag            (w_ld_tag),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_status            (o_status),
        .o_read_valid        (o_read_valid),
        .o_read_tag          (o_read_tag),
        .o_input_stage_count (o_input_stage_count),
        .o_input_stage_full  (o_input_stage_full),
        .o_entries_held      (o_entries_held)
    );

    // Ring of slot cells, each fed by its upper neighbor
    for (genvar k = 0; k < N; k++) begin : g_cell
        mep_cell #(
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd[k]),
            .i_nxt_occ (w_occ[(k + 1) % N]),
            .i_nxt_tag (w_tag[(k + 1) % N]),
            .i_ld_tag  (w_ld_tag),
            .o_occ     (w_occ[k]),
            .o_tag     (w_tag[k])
        );
    end

endmodule

### hdl/mep_checker.sv
// ----------------------------------------------------------------------------
// mep_checker
// Port-level checks of the multiport elastic pipeline, bound to the top.
// ----------------------------------------------------------------------------
module mep_checker
    import mep_pkg::*;
#(
    parameter int LANES    = 2,
    parameter int STAGES   = 4,
    parameter int TAG_BITS = 16
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_status,
    input logic                       o_read_valid,
    input logic [TAG_BITS-1:0]        o_read_tag,
    input logic [$clog2(LANES+1)-1:0] o_input_stage_count,
    input logic                       o_input_stage_full,
    input logic [CNT_W-1:0]           o_entries_held
);

    localparam int N = LANES * STAGES;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_tag)
            && $stable(o_entries_held) && $stable(o_status))
        else $error("stalled result changed");

    // Block further input while a transaction is in flight
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // A result follows each acceptance, after the ring walk and the done state
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |-> ##(N + 2) o_out_valid)
        else $error("result late");

    // Full flag follows the input stage count
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_input_stage_full == (int'(o_input_stage_count) == LANES)))
        else $error("full flag mismatch");

    // Zero the tag when peek finds nothing
    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_valid |-> (o_read_tag == '0) && !(o_status && o_read_valid))
        else $error("tag without read");

endmodule

bind multiport_elastic_pipeline mep_checker #(
    .LANES    (LANES),
    .STAGES   (STAGES),
    .TAG_BITS (TAG_BITS)
) u_mep_checker (.*);
